### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every rising clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// condition that must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

### rtl/core/csvft_pkg.sv
// ----------------------------------------------------------------------------
// csvft_pkg
// types and constants of the csv field tokenizer
// ----------------------------------------------------------------------------
package csvft_pkg;

  // operation codes of an input transaction
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_EOL  = 1'b1;

  // result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_FIELD = 2'd1;
  localparam logic [1:0] KIND_ROW   = 2'd2;
  localparam logic [1:0] KIND_ERROR = 2'd3;

  // byte order mark progress
  localparam logic [1:0] MARK_START = 2'd0;
  localparam logic [1:0] MARK_EF    = 2'd1;
  localparam logic [1:0] MARK_EFBB  = 2'd2;
  localparam logic [1:0] MARK_DONE  = 2'd3;

  // characters
  localparam logic [7:0] MARK_B0  = 8'hEF;
  localparam logic [7:0] MARK_B1  = 8'hBB;
  localparam logic [7:0] MARK_B2  = 8'hBF;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // most results one input transaction can cause
  localparam int unsigned MaxResults = 3;

  typedef struct packed {
    logic       operation;
    logic [7:0] text_byte;
    logic       final_line;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] result_kind;
    logic       last_of_run;
  } out_item_t;

endpackage

### rtl/core/csv_field_tokenizer_unit.sv
// ----------------------------------------------------------------------------
// csv_field_tokenizer_unit
// streaming csv tokenizer: quoting, field and row ends, byte order mark skip
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid_i / in_ready_o / in_item_i) takes one text byte or
//   one end-of-line marker per transaction. out channel (out_valid_o /
//   out_ready_i / out_item_o) gives data bytes, field ends, row ends and the
//   unterminated quote error, with last_of_run on the final result of each
//   input transaction. an input that causes no result shows nothing.
// path: an accepted transaction is held in the input register, is decoded
//   into the result buffer, and its first result is shown from entry 0.
// throughput: one input per cycle while each input yields at most one
//   result and out_ready_i stays high; an input yielding more results
//   (at most three, when held mark bytes are released) holds back the next
//   input until the single result port drains the three-entry result buffer.
// reset: quote state cleared, mark check armed for a new file, both
//   registers empty.
// stall: when out_ready_i is low the result buffer holds, the input register
//   fills, and in_ready_o drops until the buffer can take the next input.
// ----------------------------------------------------------------------------
module csv_field_tokenizer_unit
  import csvft_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  // input register
  logic     item_valid_q, item_valid_d;
  in_item_t item_q;

  // tokenizer state
  logic       ins_q, ins_d;
  logic       qp_q, qp_d;
  logic [1:0] ms_q, ms_d;

  // result buffer, entry 0 is shown
  out_item_t res_q [MaxResults];
  out_item_t res_d [MaxResults];
  logic [1:0] cnt_q, cnt_d;

  logic in_fire, out_fire, load;

  // decode signals
  logic       do_release;
  logic [1:0] held_n;
  logic       emit_v;
  logic [7:0] emit_byte;
  logic [1:0] emit_kind;
  logic [1:0] new_n;
  logic       ins_v;
  logic       quote_taken;
  out_item_t  new_res [MaxResults];

  assign out_valid_o = (cnt_q != 2'd0);
  assign out_item_o  = res_q[0];
  assign out_fire    = out_valid_o && out_ready_i;
  assign load        = item_valid_q && ((cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_fire));
  assign in_ready_o  = !item_valid_q || load;
  assign in_fire     = in_valid_i && in_ready_o;

  // per-item decode against current state
  always_comb begin
    ins_d       = ins_q;
    qp_d        = qp_q;
    ms_d        = ms_q;
    do_release  = 1'b0;
    emit_v      = 1'b0;
    emit_byte   = 8'd0;
    emit_kind   = KIND_DATA;
    ins_v       = ins_q;
    quote_taken = 1'b0;
    if (item_q.operation == OP_BYTE) begin
      if (ms_q == MARK_START && item_q.text_byte == MARK_B0) begin
        ms_d = MARK_EF;
      end else if (ms_q == MARK_EF && item_q.text_byte == MARK_B1) begin
        ms_d = MARK_EFBB;
      end else if (ms_q == MARK_EFBB && item_q.text_byte == MARK_B2) begin
        ms_d = MARK_DONE;
      end else begin
        do_release = 1'b1;
        ms_d       = MARK_DONE;
        // pending quote decides doubled or closing
        if (qp_q) begin
          qp_d = 1'b0;
          if (item_q.text_byte == CH_QUOTE) begin
            emit_v      = 1'b1;
            emit_byte   = CH_QUOTE;
            quote_taken = 1'b1;
          end else begin
            ins_v = 1'b0;
          end
        end
        if (!quote_taken) begin
          if (item_q.text_byte == CH_QUOTE) begin
            if (ins_v) begin
              qp_d = 1'b1;
            end else begin
              ins_v = 1'b1;
            end
          end else if (item_q.text_byte == CH_COMMA) begin
            emit_v = 1'b1;
            if (ins_v) begin
              emit_byte = CH_COMMA;
            end else begin
              emit_kind = KIND_FIELD;
            end
          end else if (item_q.text_byte != CH_CR) begin
            emit_v    = 1'b1;
            emit_byte = item_q.text_byte;
          end
        end
        ins_d = ins_v;
      end
    end else begin
      // end of line
      do_release = 1'b1;
      if (qp_q) begin
        qp_d  = 1'b0;
        ins_v = 1'b0;
      end
      emit_v = 1'b1;
      if (ins_v) begin
        if (item_q.final_line) begin
          emit_kind = KIND_ERROR;
          ins_v     = 1'b0;
        end else begin
          emit_byte = CH_LF;
        end
      end else begin
        emit_kind = KIND_ROW;
      end
      ins_d = ins_v;
      ms_d  = item_q.final_line ? MARK_START : MARK_DONE;
    end
  end

  // assemble released mark bytes and the final result
  always_comb begin
    held_n = 2'd0;
    if (do_release) begin
      unique case (ms_q)
        MARK_EF:   held_n = 2'd1;
        MARK_EFBB: held_n = 2'd2;
        default:   held_n = 2'd0;
      endcase
    end
    new_n = held_n + {1'b0, emit_v};
    for (int i = 0; i < MaxResults; i++) begin
      new_res[i] = '0;
      if (2'(i) < held_n) begin
        new_res[i].data_byte = (i == 0) ? MARK_B0 : MARK_B1;
      end else if (2'(i) == held_n && emit_v) begin
        new_res[i].data_byte   = emit_byte;
        new_res[i].result_kind = emit_kind;
      end
      new_res[i].last_of_run = (new_n != 2'd0) && (2'(i) == new_n - 2'd1);
    end
  end

  // result buffer next value
  always_comb begin
    cnt_d = cnt_q;
    for (int i = 0; i < MaxResults; i++) begin
      res_d[i] = res_q[i];
    end
    if (load) begin
      cnt_d = new_n;
      for (int i = 0; i < MaxResults; i++) begin
        res_d[i] = new_res[i];
      end
    end else if (out_fire) begin
      cnt_d = cnt_q - 2'd1;
      for (int i = 0; i < MaxResults - 1; i++) begin
        res_d[i] = res_q[i + 1];
      end
    end
  end

  assign item_valid_d = in_fire || (item_valid_q && !load);

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
      cnt_q        <= 2'd0;
      ins_q        <= 1'b0;
      qp_q         <= 1'b0;
      ms_q         <= MARK_START;
    end else begin
      item_valid_q <= item_valid_d;
      cnt_q        <= cnt_d;
      if (load) begin
        ins_q <= ins_d;
        qp_q  <= qp_d;
        ms_q  <= ms_d;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_item_i;
    end
    for (int i = 0; i < MaxResults; i++) begin
      res_q[i] <= res_d[i];
    end
  end

endmodule

### rtl/core/csvft_checker.sv
// ----------------------------------------------------------------------------
// csvft_checker
// port-level checks of the csv field tokenizer, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module csvft_checker
  import csvft_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_item_o
);

  // shown result is not a data byte yet carries a nonzero byte
  logic nondata_byte;
  assign nondata_byte = (out_item_o.result_kind != KIND_DATA) &&
                        (out_item_o.data_byte != 8'd0);

  // a shown transaction stays until taken
  `ASSERT_PROP(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o)

  // a stalled payload does not change
  `ASSERT_PROP(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i |=> $stable(out_item_o))

  // non-data results carry a zero byte
  `ASSERT_NEVER(a_kind_byte, clk_i, rst_ni, out_valid_o && nondata_byte)

  // an empty output side always takes input
  `ASSERT_PROP(a_ready_when_empty, clk_i, rst_ni, !out_valid_o |-> in_ready_o)

endmodule

bind csv_field_tokenizer_unit csvft_checker u_csvft_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

### sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// testbench of csv_field_tokenizer_unit: feeds byte-order-mark cases, quoted
// and plain fields, multi-line quotes and random noise, with random stalls on
// both channels, and checks every result against a tokenizer predictor
// ----------------------------------------------------------------------------
module tb;
  import csvft_pkg::*;

  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned RandomTarget = 270;

  // tokenizer predictor and result scoreboard
  class tokenizer_scoreboard;
    logic        in_quotes = 1'b0;
    logic        quote_held = 1'b0;
    logic [1:0]  bom_stage = MARK_START;
    out_item_t   expected_tokens[$];
    out_item_t   run_tokens[$];
    int unsigned mismatches = 0;
    int unsigned checked = 0;

    function void push_token(logic [7:0] b, logic [1:0] kind);
      out_item_t t;
      t.data_byte   = b;
      t.result_kind = kind;
      t.last_of_run = 1'b0;
      run_tokens = {run_tokens, t};
    endfunction

    // held mark prefix goes out as plain data
    function void release_bom();
      if (bom_stage == MARK_EF || bom_stage == MARK_EFBB) push_token(MARK_B0, KIND_DATA);
      if (bom_stage == MARK_EFBB) push_token(MARK_B1, KIND_DATA);
      bom_stage = MARK_DONE;
    endfunction

    function void tokenize_byte(logic [7:0] b);
      // a held quote is either doubled or closes the run
      if (quote_held) begin
        quote_held = 1'b0;
        if (b == CH_QUOTE) begin
          push_token(CH_QUOTE, KIND_DATA);
          return;
        end
        in_quotes = 1'b0;
      end
      if (b == CH_QUOTE) begin
        if (in_quotes) quote_held = 1'b1;
        else in_quotes = 1'b1;
      end else if (b == CH_COMMA) begin
        if (in_quotes) push_token(b, KIND_DATA);
        else push_token(8'h00, KIND_FIELD);
      end else if (b != CH_CR) begin
        push_token(b, KIND_DATA);
      end
    endfunction

    // note one accepted input transaction, returns its number of results
    function int unsigned predict_tokens(in_item_t it);
      int unsigned n;
      run_tokens.delete();
      if (it.operation == OP_BYTE) begin
        if (bom_stage == MARK_START && it.text_byte == MARK_B0) bom_stage = MARK_EF;
        else if (bom_stage == MARK_EF && it.text_byte == MARK_B1) bom_stage = MARK_EFBB;
        else if (bom_stage == MARK_EFBB && it.text_byte == MARK_B2) bom_stage = MARK_DONE;
        else begin
          release_bom();
          tokenize_byte(it.text_byte);
        end
      end else begin
        release_bom();
        if (quote_held) begin
          quote_held = 1'b0;
          in_quotes  = 1'b0;
        end
        if (in_quotes) begin
          if (it.final_line) begin
            push_token(8'h00, KIND_ERROR);
            in_quotes = 1'b0;
          end else begin
            push_token(CH_LF, KIND_DATA);
          end
        end else begin
          push_token(8'h00, KIND_ROW);
        end
        bom_stage = it.final_line ? MARK_START : MARK_DONE;
      end
      n = run_tokens.size();
      if (n > 0) run_tokens[n-1].last_of_run = 1'b1;
      expected_tokens = {expected_tokens, run_tokens};
      return n;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    // compare one accepted result with the oldest expectation
    task check_token(out_item_t got);
      out_item_t want;
      if (expected_tokens.size() == 0) begin
        report($sformatf("unexpected result kind %0d byte %02h",
                         got.result_kind, got.data_byte));
        return;
      end
      want = expected_tokens.pop_front();
      checked++;
      if (got.result_kind !== want.result_kind)
        report($sformatf("result_kind %0d, expected %0d", got.result_kind, want.result_kind));
      if (got.data_byte !== want.data_byte)
        report($sformatf("data_byte %02h, expected %02h", got.data_byte, want.data_byte));
      if (got.last_of_run !== want.last_of_run)
        report($sformatf("last_of_run %0b, expected %0b", got.last_of_run, want.last_of_run));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_item;

  tokenizer_scoreboard sb = new();
  logic        no_idle = 1'b0;
  int unsigned productive_items = 0;
  int unsigned sent_items = 0;
  int unsigned idle_cycles = 0;
  int unsigned files_sent = 0;

  csv_field_tokenizer_unit dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_item_i  (in_item),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_item_o (out_item)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // gap length: mostly short, a few long
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // text byte with weight on the characters the tokenizer cares about
  function automatic logic [7:0] pick_text();
    case ($urandom_range(0, 11))
      0: return 8'($urandom_range(0, 255));
      1: return CH_CR;
      2: return CH_COMMA;
      3: begin
        case ($urandom_range(0, 2))
          0: return MARK_B0;
          1: return MARK_B1;
          default: return MARK_B2;
        endcase
      end
      default: return 8'($urandom_range(8'h20, 8'h7E));
    endcase
  endfunction

  // sample both channels, predict, check, watch for a hang
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        if (sb.predict_tokens(in_item) > 0) productive_items++;
        sent_items++;
      end
      if (out_valid && out_ready) sb.check_token(out_item);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("timeout after %0d cycles without a transaction", idle_cycles);
        $display("csv_field_tokenizer_unit verification failed");
        $finish;
      end
    end
  end

  // result side stalls
  initial begin
    int unsigned gap;
    @(posedge rst_n);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // drive one input transaction, called at a falling edge
  task automatic send_item(in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_item  = it;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // text byte, final_line is don't-care and randomized
  task automatic send_byte(logic [7:0] b);
    in_item_t it;
    it.operation  = OP_BYTE;
    it.text_byte  = b;
    it.final_line = 1'($urandom_range(0, 1));
    send_item(it);
  endtask

  // line end, text_byte is don't-care and randomized
  task automatic send_eol(logic fin);
    in_item_t it;
    it.operation  = OP_EOL;
    it.text_byte  = 8'($urandom_range(0, 255));
    it.final_line = fin;
    send_item(it);
  endtask

  // one field, quoted or plain
  task automatic send_field();
    int unsigned n;
    logic [7:0]  b;
    n = $urandom_range(0, 5);
    if ($urandom_range(0, 2) == 0) begin
      send_byte(CH_QUOTE);
      repeat (n) begin
        if ($urandom_range(0, 7) == 0) send_eol(1'b0);
        else if ($urandom_range(0, 5) == 0) begin
          send_byte(CH_QUOTE);
          send_byte(CH_QUOTE);
        end else begin
          send_byte(pick_text());
        end
      end
      if ($urandom_range(0, 11) != 0) send_byte(CH_QUOTE);
    end else begin
      repeat (n) begin
        b = pick_text();
        if (b == CH_QUOTE && $urandom_range(0, 3) != 0) b = 8'h78;
        send_byte(b);
      end
    end
  endtask

  task automatic send_line(logic fin);
    int unsigned k;
    k = $urandom_range(1, 4);
    for (int unsigned i = 0; i < k; i++) begin
      if (i > 0) send_byte(CH_COMMA);
      send_field();
    end
    if ($urandom_range(0, 2) == 0) send_byte(CH_CR);
    send_eol(fin);
  endtask

  // a whole file: optional mark, full or cut, then a few lines
  task automatic send_file();
    int unsigned lines;
    case ($urandom_range(0, 5))
      0, 1: begin
        send_byte(MARK_B0);
        send_byte(MARK_B1);
        send_byte(MARK_B2);
      end
      2: send_byte(MARK_B0);
      3: begin
        send_byte(MARK_B0);
        send_byte(MARK_B1);
      end
      default: ;
    endcase
    lines = $urandom_range(1, 3);
    for (int unsigned i = 0; i < lines; i++) send_line(i == lines - 1);
  endtask

  // fully random transactions
  task automatic send_noise();
    in_item_t it;
    repeat ($urandom_range(3, 10)) begin
      it.operation  = ($urandom_range(0, 4) == 0) ? OP_EOL : OP_BYTE;
      it.text_byte  = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 255)) : pick_text();
      it.final_line = 1'($urandom_range(0, 1));
      send_item(it);
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // full mark, quoting rules, doubled quote, held quote then carriage return
    send_byte(MARK_B0);
    send_byte(MARK_B1);
    send_byte(MARK_B2);
    send_byte(8'h61);
    send_byte(CH_COMMA);
    send_byte(CH_QUOTE);
    send_byte(CH_COMMA);
    send_byte(CH_QUOTE);
    send_byte(CH_QUOTE);
    send_byte(CH_QUOTE);
    send_byte(CH_CR);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_eol(1'b0);
    // newline inside quotes, then held quote at the final line end
    send_byte(CH_QUOTE);
    send_byte(8'h71);
    send_eol(1'b0);
    send_byte(CH_QUOTE);
    send_eol(1'b1);
    // mark broken by a byte, releasing two held bytes
    send_byte(MARK_B0);
    send_byte(MARK_B1);
    send_byte(8'h00);
    // unterminated quote on the last line
    send_byte(CH_QUOTE);
    send_eol(1'b1);
    // mark cut by a line end
    send_byte(MARK_B0);
    send_byte(MARK_B1);
    send_eol(1'b1);

    // random files, with bursts of noise
    while (sent_items < RandomTarget) begin
      no_idle = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 6) == 0) send_noise();
      else send_file();
      files_sent++;
    end
    no_idle  = 1'b0;
    in_valid = 1'b0;

    // drain, then allow for stray results
    while (sb.expected_tokens.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.expected_tokens.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_tokens.size()));

    $display("covered %0d input transactions (%0d with results) over %0d files or noise bursts",
             sent_items, productive_items, files_sent);
    $display("%0d results compared, %0d mismatches", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("csv_field_tokenizer_unit verification clean");
    end else begin
      $display("csv_field_tokenizer_unit verification failed");
    end
    $finish;
  end

endmodule

### files.f
+incdir+rtl/core
rtl/core/csvft_pkg.sv
rtl/core/csv_field_tokenizer_unit.sv
rtl/core/csvft_checker.sv
sim/tb.sv
